### hdl/hkh_pkg.sv
// Package for the hex key hash table match core.
// Holds widths, codes, the job record and the hash arithmetic helpers.
// No dependencies.
`timescale 1ns / 1ps

package hkh_pkg;

    // Hash and table geometry
    localparam int HASH_BITS   = 16;
    localparam int MULT_W      = 16;
    localparam int KEY_W       = 24;
    localparam int CHAR_W      = 8;
    localparam int VAL_W       = 6;
    localparam int TABLE_DEPTH = (2 ** HASH_BITS) - 1;

    // Product folding over HASH_BITS-wide chunks
    localparam int PROD_W  = HASH_BITS + MULT_W;
    localparam int NCHUNK  = (PROD_W + HASH_BITS - 1) / HASH_BITS;
    localparam int PAD_W   = NCHUNK * HASH_BITS;
    localparam int SUM_W   = HASH_BITS + 4;

    // Stream widths, whole bytes
    localparam int IN_TDATA_W  = ((CHAR_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((KEY_W + HASH_BITS + 7) / 8) * 8;

    // Queue between front and back
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    localparam logic [MULT_W-1:0]    FIRST_MULT_RESET  = MULT_W'(31);
    localparam logic [MULT_W-1:0]    SECOND_MULT_RESET = MULT_W'(37);
    localparam logic [KEY_W-1:0]     COUNT_MAX         = {KEY_W{1'b1}};
    localparam logic [HASH_BITS:0]   MOD_VAL           = {1'b0, {HASH_BITS{1'b1}}};
    localparam logic [HASH_BITS-1:0] LAST_ADDR         = HASH_BITS'(TABLE_DEPTH - 1);

    // Opcodes carried on tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_PROBE  = 1'b1;

    // Configuration register indexes
    localparam logic REG_FIRST_MULT  = 1'b0;
    localparam logic REG_SECOND_MULT = 1'b1;

    typedef enum logic [1:0] {
        OUT_INSERTED = 2'd0,
        OUT_HIT      = 2'd1,
        OUT_MISS     = 2'd2,
        OUT_BAD      = 2'd3
    } t_outcome;

    // One finished key handed from front to back
    typedef struct packed {
        logic                 op;
        logic                 bad;
        logic [HASH_BITS-1:0] h1;
        logic [HASH_BITS-1:0] h2;
    } t_job;

    // Character class: {allowed, value}
    function automatic logic [VAL_W:0] char_value(input logic [CHAR_W-1:0] c);
        logic [VAL_W:0] res;
        res = '0;
        if (c >= CHAR_W'(8'h30) && c <= CHAR_W'(8'h3A)) begin
            res = {1'b1, VAL_W'(c - CHAR_W'(8'h30))};
        end else if (c >= CHAR_W'(8'h61) && c <= CHAR_W'(8'h7A)) begin
            res = {1'b1, VAL_W'(c - CHAR_W'(8'h61) + CHAR_W'(10))};
        end
        return res;
    endfunction

    // (p mod M + v) mod M with M = 2^HASH_BITS - 1, by chunk folding
    function automatic logic [HASH_BITS-1:0] roll_fold(input logic [PROD_W-1:0] p,
                                                        input logic [VAL_W-1:0] v);
        logic [PAD_W-1:0]   pp;
        logic [SUM_W-1:0]   s;
        logic [HASH_BITS:0] t;
        pp = PAD_W'(p);
        s  = SUM_W'(v);
        for (int i = 0; i < NCHUNK; i++) begin
            s = s + SUM_W'(pp[i*HASH_BITS +: HASH_BITS]);
        end
        t = (HASH_BITS + 1)'(s[HASH_BITS-1:0]) + (HASH_BITS + 1)'(s[SUM_W-1:HASH_BITS]);
        if (t >= MOD_VAL) begin
            t = t - MOD_VAL;
        end
        if (t >= MOD_VAL) begin
            t = t - MOD_VAL;
        end
        return t[HASH_BITS-1:0];
    endfunction

endpackage

### hdl/hkh_front.sv
// Front end: takes key characters, keeps both rolling hashes and the
// bad flag, and pushes one job per finished key. Holds the config registers.
// Depends on hkh_pkg.
`timescale 1ns / 1ps

module hkh_front import hkh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [MULT_W-1:0]     i_cfg_data,
    // Character stream
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CHAR_W-1:0]     i_char,
    input  logic                  i_end,
    input  logic                  i_op,
    // Back end is done clearing the tables
    input  logic                  i_clr_done,
    // Job queue push side
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_job                  o_job
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_ADD  = 2'b10
    } t_front_state;

    t_front_state         r_state;
    logic [MULT_W-1:0]    r_m1, r_m2;
    logic [HASH_BITS-1:0] r_h1, r_h2;
    logic                 r_bad;
    logic [PROD_W-1:0]    r_p1, r_p2;
    logic [VAL_W:0]       r_cv;
    logic                 r_end, r_op;

    logic [HASH_BITS-1:0] n_h1, n_h2;
    logic                 n_bad;
    logic                 w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == F_IDLE) && i_clr_done;
    assign w_accept    = i_valid && o_ready;

    // Finish one hash step; a bad character leaves the hashes alone
    always_comb begin
        n_h1  = r_h1;
        n_h2  = r_h2;
        n_bad = r_bad | ~r_cv[VAL_W];
        if (r_cv[VAL_W]) begin
            n_h1 = roll_fold(r_p1, r_cv[VAL_W-1:0]);
            n_h2 = roll_fold(r_p2, r_cv[VAL_W-1:0]);
        end
    end

    assign o_push = (r_state == F_ADD) && r_end && !i_q_full;
    assign o_job  = '{op: r_op, bad: n_bad, h1: n_h1, h2: n_h2};

    // Product of the running hash and multiplier, registered before the fold
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1  <= PROD_W'(r_h1) * PROD_W'(r_m1);
            r_p2  <= PROD_W'(r_h2) * PROD_W'(r_m2);
            r_cv  <= char_value(i_char);
            r_end <= i_end;
            r_op  <= i_op;
        end
    end

    // Config registers, hash state and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_m1    <= FIRST_MULT_RESET;
            r_m2    <= SECOND_MULT_RESET;
            r_h1    <= '0;
            r_h2    <= '0;
            r_bad   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_FIRST_MULT:  r_m1 <= i_cfg_data;
                    REG_SECOND_MULT: r_m2 <= i_cfg_data;
                    default:         ;
                endcase
            end
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        r_state <= F_ADD;
                    end
                end
                F_ADD: begin
                    if (!r_end) begin
                        r_h1    <= n_h1;
                        r_h2    <= n_h2;
                        r_bad   <= n_bad;
                        r_state <= F_IDLE;
                    end else if (!i_q_full) begin
                        // Key handed off: restart the hashes
                        r_h1    <= '0;
                        r_h2    <= '0;
                        r_bad   <= 1'b0;
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

### hdl/hkh_queue.sv
// Short job queue between the front and back ends.
// Depends on hkh_pkg.
`timescale 1ns / 1ps

module hkh_queue import hkh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rd];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

### hdl/hkh_back.sv
// Back end: clears both key tables after reset, then carries out inserts
// and probes from the job queue and holds the result register.
// Depends on hkh_pkg.
`timescale 1ns / 1ps

module hkh_back import hkh_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Job queue pop side
    input  logic                 i_q_empty,
    input  t_job                 i_q_head,
    output logic                 o_pop,
    output logic                 o_clr_done,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_outcome             o_outcome,
    output logic [KEY_W-1:0]     o_number,
    output logic [HASH_BITS-1:0] o_bucket
);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_CMP   = 3'b100
    } t_back_state;

    t_back_state          r_state;
    logic [HASH_BITS-1:0] r_clr_addr;
    logic [KEY_W-1:0]     r_count;
    t_job                 r_job;
    logic [KEY_W-1:0]     r_rd1, r_rd2;
    logic [KEY_W-1:0]     r_mem1 [TABLE_DEPTH];
    logic [KEY_W-1:0]     r_mem2 [TABLE_DEPTH];
    logic                 r_out_valid;
    t_outcome             r_outcome;
    logic [KEY_W-1:0]     r_number;
    logic [HASH_BITS-1:0] r_bucket;

    logic                 w_out_free;
    logic                 w_we;
    logic [HASH_BITS-1:0] w_waddr1, w_waddr2;
    logic [KEY_W-1:0]     w_wdata;
    logic [KEY_W-1:0]     n_count;
    logic                 n_out_valid;
    logic                 w_hit;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = (r_state == B_IDLE) && !i_q_empty && w_out_free;
    assign o_clr_done = (r_state != B_CLEAR);
    assign n_count    = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
    assign w_hit      = (r_rd1 != '0) && (r_rd1 == r_rd2);

    // Raise valid when a result is loaded, drop it once transferred
    assign n_out_valid = (o_pop && (i_q_head.bad || i_q_head.op == OP_INSERT))
                         || (r_state == B_CMP) || (r_out_valid && !i_ready);

    // Table write port: clearing sweep or an insert
    always_comb begin
        w_we     = 1'b0;
        w_waddr1 = r_clr_addr;
        w_waddr2 = r_clr_addr;
        w_wdata  = '0;
        if (r_state == B_CLEAR) begin
            w_we = 1'b1;
        end else if (o_pop && !i_q_head.bad && i_q_head.op == OP_INSERT) begin
            w_we     = 1'b1;
            w_waddr1 = i_q_head.h1;
            w_waddr2 = i_q_head.h2;
            w_wdata  = n_count;
        end
    end

    // Tables with registered reads at the queue head's hashes
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem1[w_waddr1] <= w_wdata;
        end
        r_rd1 <= r_mem1[i_q_head.h1];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem2[w_waddr2] <= w_wdata;
        end
        r_rd2 <= r_mem2[i_q_head.h2];
    end

    // Hold the popped job for the compare cycle
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_head;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_q_head.bad) begin
                r_outcome <= OUT_BAD;
                r_number  <= '0;
                r_bucket  <= '0;
            end else begin
                r_outcome <= OUT_INSERTED;
                r_number  <= n_count;
                r_bucket  <= i_q_head.h1;
            end
        end else if (r_state == B_CMP) begin
            r_outcome <= w_hit ? OUT_HIT : OUT_MISS;
            r_number  <= w_hit ? r_rd1 - 1'b1 : '0;
            r_bucket  <= r_job.h1;
        end
    end

    // Sequencing, key count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_pop && !i_q_head.bad) begin
                        if (i_q_head.op == OP_INSERT) begin
                            r_count <= n_count;
                        end else begin
                            r_state <= B_CMP;
                        end
                    end
                end
                B_CMP: begin
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid   = r_out_valid;
    assign o_outcome = r_outcome;
    assign o_number  = r_number;
    assign o_bucket  = r_bucket;

endmodule

### hdl/hex_key_hash_table_match_core.sv
// Hex key hash table match core: takes a key character only when idle and
// finishes it (multiply, then fold into the rolling hashes) before the next.
// A key end goes through the job queue to the back end; a probe adds a table read.
// Reset is synchronous, active low; after it both tables are cleared one
// entry a cycle, all 65535 entries, with s_axis_tready low. Config writes are
// taken throughout. Depends on hkh_pkg, hkh_front, hkh_queue, hkh_back.
`timescale 1ns / 1ps

module hex_key_hash_table_match_core import hkh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [MULT_W-1:0]      i_cfg_data,
    // Key character stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] key_char
    input  logic                   s_axis_tlast,   // key_end
    input  logic                   s_axis_tuser,   // [0] opcode
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [23:0] key_number, [39:24] bucket
    output logic [1:0]             m_axis_tuser    // [1:0] outcome
);

    logic                 w_clr_done;
    logic                 w_q_full, w_q_empty;
    logic                 w_push, w_pop;
    t_job                 w_push_job, w_head;
    t_outcome             w_outcome;
    logic [KEY_W-1:0]     w_number;
    logic [HASH_BITS-1:0] w_bucket;

    hkh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_char      (s_axis_tdata[CHAR_W-1:0]),
        .i_end       (s_axis_tlast),
        .i_op        (s_axis_tuser),
        .i_clr_done  (w_clr_done),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    hkh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    hkh_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_head   (w_head),
        .o_pop      (w_pop),
        .o_clr_done (w_clr_done),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_outcome  (w_outcome),
        .o_number   (w_number),
        .o_bucket   (w_bucket)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = OUT_TDATA_W'({w_bucket, w_number});
    assign m_axis_tuser = w_outcome;

endmodule

### sim/hex_key_hash_table_match_core_test.sv
// Testbench for hex_key_hash_table_match_core: streams hex keys, predicts each
// insert, probe and bad-key outcome in a scoreboard and compares every result.
// Depends on hkh_pkg and the core RTL.
`timescale 1ns / 1ps

module hex_key_hash_table_match_core_test;
    import hkh_pkg::*;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam longint unsigned HASH_MOD = (64'd1 << HASH_BITS) - 64'd1;
    localparam int SETTLE_CYCLES = 8;
    localparam int KEY_MAX_LEN = 8;

    typedef struct {
        t_outcome             outcome;
        logic [KEY_W-1:0]     number;
        logic [HASH_BITS-1:0] bucket;
    } t_key_report;

    typedef struct {
        logic [8*KEY_MAX_LEN-1:0] text;
        int                       len;
    } t_key_text;

    // Hash table predictor and store of pending key reports
    class t_key_table_board;
        t_key_report          expected_q[$];
        int                   errors;
        logic [MULT_W-1:0]    mult_a;
        logic [MULT_W-1:0]    mult_b;
        logic [HASH_BITS-1:0] run_a;
        logic [HASH_BITS-1:0] run_b;
        logic                 key_bad;
        logic [KEY_W-1:0]     key_count;
        logic [KEY_W-1:0]     slots_a[logic [HASH_BITS-1:0]];
        logic [KEY_W-1:0]     slots_b[logic [HASH_BITS-1:0]];

        function new();
            errors    = 0;
            mult_a    = 16'd31;
            mult_b    = 16'd37;
            run_a     = '0;
            run_b     = '0;
            key_bad   = 1'b0;
            key_count = '0;
        endfunction

        function void set_mult(logic idx, logic [MULT_W-1:0] value);
            if (idx == REG_FIRST_MULT) begin
                mult_a = value;
            end else begin
                mult_b = value;
            end
        endfunction

        // Digits and ':' weigh 0..10, lowercase letters 10..35, -1 for the rest
        function int digit_weight(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_COLON) begin
                return int'(c - CH_ZERO);
            end
            if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
                return int'(c - CH_LOW_A) + 10;
            end
            return -1;
        endfunction

        function logic [HASH_BITS-1:0] fold_step(logic [HASH_BITS-1:0] h,
                                                 logic [MULT_W-1:0] m, int w);
            longint unsigned acc;
            acc = (longint'(h) * longint'(m)) % HASH_MOD;
            acc = (acc + longint'(w)) % HASH_MOD;
            return acc[HASH_BITS-1:0];
        endfunction

        // Advance the running hashes; at a key end, predict the report
        function void note_char(logic op, logic [7:0] c, logic last);
            int               w;
            t_key_report      r;
            logic [KEY_W-1:0] na;
            logic [KEY_W-1:0] nb;
            w = digit_weight(c);
            if (w < 0) begin
                key_bad = 1'b1;
            end else begin
                run_a = fold_step(run_a, mult_a, w);
                run_b = fold_step(run_b, mult_b, w);
            end
            if (!last) begin
                return;
            end
            r.outcome = OUT_BAD;
            r.number  = '0;
            r.bucket  = '0;
            if (!key_bad) begin
                r.bucket = run_a;
                if (op == OP_INSERT) begin
                    if (key_count != COUNT_MAX) begin
                        key_count++;
                    end
                    slots_a[run_a] = key_count;
                    slots_b[run_b] = key_count;
                    r.outcome = OUT_INSERTED;
                    r.number  = key_count;
                end else begin
                    na = slots_a.exists(run_a) ? slots_a[run_a] : '0;
                    nb = slots_b.exists(run_b) ? slots_b[run_b] : '0;
                    if (na != '0 && na == nb) begin
                        r.outcome = OUT_HIT;
                        r.number  = na - 1'b1;
                    end else begin
                        r.outcome = OUT_MISS;
                    end
                end
            end
            expected_q.push_back(r);
            run_a   = '0;
            run_b   = '0;
            key_bad = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Compare one result transfer with the oldest prediction
        task check_result(logic [1:0] outcome, logic [KEY_W-1:0] number,
                          logic [HASH_BITS-1:0] bucket);
            t_key_report want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result outcome %0d number %0d bucket %0d",
                                 outcome, number, bucket));
                return;
            end
            want = expected_q.pop_front();
            if (outcome !== want.outcome) begin
                report($sformatf("outcome %0d, want %0d", outcome, want.outcome));
            end
            if (number !== want.number) begin
                report($sformatf("key number %0d, want %0d", number, want.number));
            end
            if (bucket !== want.bucket) begin
                report($sformatf("bucket %0d, want %0d", bucket, want.bucket));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index = REG_FIRST_MULT;
    logic [MULT_W-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] key_char
    logic                   s_axis_tlast = 1'b0; // key_end
    logic                   s_axis_tuser = 1'b0; // [0] opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [23:0] key_number, [39:24] bucket
    logic [1:0]             m_axis_tuser;        // [1:0] outcome

    t_key_table_board sb = new();
    t_key_text        key_library[$];
    int               tx_idle_pct = 32;
    int               rx_idle_pct = 54;
    int               tx_burst = 0;
    int               rx_burst = 0;
    int               chars_sent = 0;

    hex_key_hash_table_match_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Check result transfers; stall the result side at random, with bursts of ready
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata[KEY_W-1:0],
                            m_axis_tdata[KEY_W +: HASH_BITS]);
        end
        if (rx_burst > 0) begin
            rx_burst--;
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(99) < 2) begin
            rx_burst = $urandom_range(60, 20);
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Send one key character, with a random gap ahead of it
    task automatic send_char(logic op, logic [7:0] c, logic last);
        if (tx_burst > 0) begin
            tx_burst--;
        end else if ($urandom_range(99) < 3) begin
            tx_burst = $urandom_range(60, 20);
        end else begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(c);
        s_axis_tlast  <= last;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_char(op, c, last);
        chars_sent++;
    endtask

    // Only the opcode on the key end counts; scramble it elsewhere
    task automatic send_key(logic op, t_key_text k);
        for (int i = 0; i < k.len; i++) begin
            if (i == k.len - 1) begin
                send_char(op, k.text[i*8 +: 8], 1'b1);
            end else begin
                send_char(1'($urandom_range(1)), k.text[i*8 +: 8], 1'b0);
            end
        end
    endtask

    function automatic t_key_text key_of(string s);
        t_key_text k;
        k.text = '0;
        k.len  = s.len();
        for (int i = 0; i < s.len(); i++) begin
            k.text[i*8 +: 8] = s[i];
        end
        return k;
    endfunction

    function automatic t_key_text one_char(logic [7:0] c);
        t_key_text k;
        k.text = '0;
        k.text[7:0] = c;
        k.len = 1;
        return k;
    endfunction

    // Random key, mostly hex digits; optionally spoil one character
    function automatic t_key_text make_key(logic spoil);
        t_key_text  k;
        int         r;
        logic [7:0] c;
        k.text = '0;
        k.len  = ($urandom_range(9) == 0) ? $urandom_range(KEY_MAX_LEN, 7) : $urandom_range(6, 1);
        for (int i = 0; i < k.len; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                c = CH_ZERO + 8'($urandom_range(9));
            end else if (r < 75) begin
                c = CH_LOW_A + 8'($urandom_range(5));
            end else if (r < 82) begin
                c = CH_COLON;
            end else begin
                c = CH_LOW_A + 8'($urandom_range(25));
            end
            k.text[i*8 +: 8] = c;
        end
        if (spoil) begin
            do c = 8'($urandom_range(255)); while (sb.digit_weight(c) >= 0);
            k.text[$urandom_range(k.len - 1)*8 +: 8] = c;
        end
        return k;
    endfunction

    // Hold the key stream until every pending report has come back
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both multipliers back to back; the core is idle here
    task automatic set_multipliers(logic [MULT_W-1:0] ma, logic [MULT_W-1:0] mb);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_FIRST_MULT;
        i_cfg_data  <= ma;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_mult(REG_FIRST_MULT, ma);
        i_cfg_index <= REG_SECOND_MULT;
        i_cfg_data  <= mb;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_mult(REG_SECOND_MULT, mb);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void remember_key(t_key_text k);
        if (key_library.size() < 48) begin
            key_library.push_back(k);
        end else begin
            key_library[$urandom_range(key_library.size() - 1)] = k;
        end
    endfunction

    // Mostly inserts and probes of known keys, then fresh probes and bad keys
    task automatic random_keys(int count, logic pause_midway);
        int        stop;
        int        r;
        logic      paused;
        t_key_text k;
        stop   = chars_sent + count;
        paused = 1'b0;
        while (chars_sent < stop) begin
            if (pause_midway && !paused && chars_sent >= stop - count / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 40 || key_library.size() == 0) begin
                k = make_key(1'b0);
                send_key(OP_INSERT, k);
                remember_key(k);
            end else if (r < 72) begin
                send_key(OP_PROBE, key_library[$urandom_range(key_library.size() - 1)]);
            end else if (r < 82) begin
                send_key(OP_PROBE, make_key(1'b0));
            end else if (r < 92) begin
                send_key(1'($urandom_range(1)), make_key(1'b1));
            end else begin
                send_key(OP_INSERT, key_library[$urandom_range(key_library.size() - 1)]);
            end
        end
    endtask

    initial begin
        int guard;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed keys under the reset multipliers
        send_key(OP_INSERT, key_of("0"));
        send_key(OP_INSERT, key_of("z"));
        send_key(OP_INSERT, key_of(":"));
        send_key(OP_PROBE, key_of("a"));      // colon and 'a' share a weight
        send_key(OP_PROBE, key_of("9"));
        send_key(OP_INSERT, one_char(8'h00));
        send_key(OP_PROBE, one_char(8'hFF));
        send_key(OP_INSERT, one_char(8'h2F)); // just below '0'
        send_key(OP_PROBE, one_char(8'h3B));  // just above ':'
        send_key(OP_INSERT, one_char(8'h60)); // just below 'a'
        send_key(OP_PROBE, one_char(8'h7B));  // just above 'z'
        send_key(OP_INSERT, key_of("dead"));
        send_key(OP_PROBE, key_of("dead"));
        send_key(OP_PROBE, key_of("b\x80c"));
        send_key(OP_PROBE, key_of("0"));
        random_keys(440, 1'b0);
        settle();

        set_multipliers(16'd1, 16'd65535);
        random_keys(450, 1'b1);
        settle();

        tx_idle_pct = 54;
        rx_idle_pct = 32;
        set_multipliers(16'd65535, 16'd1);
        random_keys(450, 1'b0);
        settle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_multipliers(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
        random_keys(500, 1'b1);

        // Wait out the pending reports, then the pipeline
        s_axis_tvalid <= 1'b0;
        for (guard = 0; guard < 20000 && sb.pending() != 0; guard++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d key reports never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
